### rtl/mqtt_publish_deframer_unit_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH
`define MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

### rtl/mqttpd_pkg.sv
`timescale 1ns / 1ps

package mqttpd_pkg;

   localparam int DEFAULT_MAX_LENGTH_FIELD_BYTES = 4;
   localparam int DEFAULT_COMMAND_COUNT_BITS     = 16;
   localparam int REM_BITS                        = 28;
   localparam logic [15:0] MAX_COMMAND_LEN_RESET  = 16'd1024;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_TOPIC_HI = 3'd2,
      PH_TOPIC_LO = 3'd3,
      PH_TOPIC    = 3'd4,
      PH_PAYLOAD  = 3'd5,
      PH_DISCARD  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_MID_PACKET   = 3'd1,
      ERR_LENGTH_FIELD = 3'd2,
      ERR_TOPIC        = 3'd3,
      ERR_TRUNCATED    = 3'd4
   } err_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  data;
      logic        byte_valid;
      logic        cmd_end;
      logic [15:0] length;
      err_type     err;
   } result_type;

endpackage

### rtl/mqttpd_core.sv
`timescale 1ns / 1ps

module mqttpd_core #(
   parameter int MaxLengthFieldBytes = mqttpd_pkg::DEFAULT_MAX_LENGTH_FIELD_BYTES,
   parameter int CommandCountBits    = mqttpd_pkg::DEFAULT_COMMAND_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic                   record_last,
   input  logic [15:0]            max_command_len,
   output mqttpd_pkg::result_type result
);

   localparam int RemBits = mqttpd_pkg::REM_BITS;
   localparam int LimBits = (CommandCountBits > 16) ? CommandCountBits : 16;
   localparam logic [CommandCountBits-1:0] CountMask = {CommandCountBits{1'b1}};

   mqttpd_pkg::phase_type phase_ff, phase_in;
   logic [RemBits-1:0]          rem_ff, rem_in;
   logic [1:0]                  digit_ff, digit_in;
   logic [15:0]                 topic_ff, topic_in;
   logic [7:0]                  topic_hi_ff, topic_hi_in;
   logic [CommandCountBits-1:0] count_ff, count_in;
   logic                        trunc_ff, trunc_in;

   logic [RemBits-1:0]          digit_shifted;
   logic [RemBits-1:0]          len_acc;
   logic                        len_cont;
   logic                        len_over;
   logic [RemBits-1:0]          rem_dec;
   logic [15:0]                 topic_word;
   logic [RemBits:0]            rem_after_topic;
   logic                        topic_over;
   logic [15:0]                 topic_dec;
   logic [LimBits-1:0]          limit;
   logic                        keep;
   logic [CommandCountBits-1:0] count_next;
   logic                        trunc_now;
   logic                        last;

   assign last = record_last;

   // Each length digit lands seven bits further up.
   always_comb begin
      case (digit_ff)
         2'd0:    digit_shifted = RemBits'(rx_byte[6:0]);
         2'd1:    digit_shifted = RemBits'({rx_byte[6:0], 7'd0});
         2'd2:    digit_shifted = RemBits'({rx_byte[6:0], 14'd0});
         default: digit_shifted = RemBits'({rx_byte[6:0], 21'd0});
      endcase
   end

   assign len_acc   = rem_ff | digit_shifted;
   assign len_cont  = rx_byte[7];
   assign len_over  = (({1'b0, digit_ff} + 3'd1) >= 3'(MaxLengthFieldBytes));
   assign rem_dec   = rem_ff - RemBits'(1);
   assign topic_word = {topic_hi_ff, rx_byte};
   // The borrow out of this subtract flags a topic longer than the packet.
   assign rem_after_topic = {1'b0, rem_dec} - (RemBits + 1)'(topic_word);
   assign topic_over      = rem_after_topic[RemBits];
   assign topic_dec       = topic_ff - 16'd1;

   assign limit = (LimBits'(max_command_len) < LimBits'(CountMask)) ?
                  LimBits'(max_command_len) : LimBits'(CountMask);
   assign keep       = LimBits'(count_ff) < limit;
   assign count_next = keep ? (count_ff + CommandCountBits'(1)) : count_ff;
   assign trunc_now  = trunc_ff | ~keep;

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         mqttpd_pkg::PH_LENGTH: begin
            if (len_cont && len_over) begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_DISCARD;
            end else if (len_cont) begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_LENGTH;
            end else if (len_acc == '0) begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_DISCARD;
            end else begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_TOPIC_HI;
            end
         end
         mqttpd_pkg::PH_TOPIC_HI: begin
            if (rem_dec == '0) begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_DISCARD;
            end else begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_TOPIC_LO;
            end
         end
         mqttpd_pkg::PH_TOPIC_LO: begin
            if (topic_over) begin
               phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_DISCARD;
            end else if (topic_word == '0 && rem_after_topic[RemBits-1:0] == '0) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end else if (last) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end else begin
               phase_in = (topic_word != '0) ? mqttpd_pkg::PH_TOPIC : mqttpd_pkg::PH_PAYLOAD;
            end
         end
         mqttpd_pkg::PH_TOPIC: begin
            if (topic_dec == '0 && rem_ff == '0) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end else if (last) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end else if (topic_dec == '0) begin
               phase_in = mqttpd_pkg::PH_PAYLOAD;
            end
         end
         mqttpd_pkg::PH_PAYLOAD: begin
            if (rem_dec == '0 || last) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end
         end
         mqttpd_pkg::PH_DISCARD: begin
            if (last) begin
               phase_in = mqttpd_pkg::PH_HEADER;
            end
         end
         default: begin
            phase_in = last ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_LENGTH;
         end
      endcase
   end

   // Counters and the result of the current request.
   always_comb begin
      rem_in      = rem_ff;
      digit_in    = digit_ff;
      topic_in    = topic_ff;
      topic_hi_in = topic_hi_ff;
      count_in    = count_ff;
      trunc_in    = trunc_ff;
      result      = '0;
      case (phase_ff)
         mqttpd_pkg::PH_LENGTH: begin
            rem_in = len_acc;
            if (len_cont && len_over) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_LENGTH_FIELD;
            end else if (len_cont) begin
               digit_in = digit_ff + 2'd1;
               if (last) begin
                  result.valid   = 1'b1;
                  result.cmd_end = 1'b1;
                  result.err     = mqttpd_pkg::ERR_MID_PACKET;
               end
            end else if (len_acc == '0) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_TOPIC;
            end else if (last) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_MID_PACKET;
            end
            result.length = 16'(count_ff);
         end
         mqttpd_pkg::PH_TOPIC_HI: begin
            topic_hi_in   = rx_byte;
            rem_in        = rem_dec;
            result.length = 16'(count_ff);
            if (rem_dec == '0) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_TOPIC;
            end else if (last) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_MID_PACKET;
            end
         end
         mqttpd_pkg::PH_TOPIC_LO: begin
            rem_in        = rem_dec;
            result.length = 16'(count_ff);
            if (topic_over) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_TOPIC;
            end else begin
               rem_in   = rem_after_topic[RemBits-1:0];
               topic_in = topic_word;
               if (topic_word == '0 && rem_after_topic[RemBits-1:0] == '0) begin
                  result.valid   = 1'b1;
                  result.cmd_end = 1'b1;
                  result.length  = '0;
               end else if (last) begin
                  result.valid   = 1'b1;
                  result.cmd_end = 1'b1;
                  result.err     = mqttpd_pkg::ERR_MID_PACKET;
               end
            end
         end
         mqttpd_pkg::PH_TOPIC: begin
            topic_in = topic_dec;
            if (topic_dec == '0 && rem_ff == '0) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
            end else if (last) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.length  = 16'(count_ff);
               result.err     = mqttpd_pkg::ERR_MID_PACKET;
            end
         end
         mqttpd_pkg::PH_PAYLOAD: begin
            count_in          = count_next;
            trunc_in          = trunc_now;
            rem_in            = rem_dec;
            result.data       = keep ? rx_byte : 8'd0;
            result.byte_valid = keep;
            if (rem_dec == '0) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.length  = 16'(count_next);
               result.err     = trunc_now ? mqttpd_pkg::ERR_TRUNCATED : mqttpd_pkg::ERR_NONE;
            end else if (last) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.length  = 16'(count_next);
               result.err     = mqttpd_pkg::ERR_MID_PACKET;
            end else begin
               result.valid = keep;
            end
         end
         mqttpd_pkg::PH_DISCARD: begin
            result = '0;
         end
         default: begin
            // Header byte: its type is not checked, every packet counter restarts.
            rem_in      = '0;
            digit_in    = '0;
            topic_in    = '0;
            topic_hi_in = '0;
            count_in    = '0;
            trunc_in    = 1'b0;
            if (last) begin
               result.valid   = 1'b1;
               result.cmd_end = 1'b1;
               result.err     = mqttpd_pkg::ERR_MID_PACKET;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mqttpd_pkg::PH_HEADER;
         rem_ff      <= '0;
         digit_ff    <= '0;
         topic_ff    <= '0;
         topic_hi_ff <= '0;
         count_ff    <= '0;
         trunc_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         rem_ff      <= rem_in;
         digit_ff    <= digit_in;
         topic_ff    <= topic_in;
         topic_hi_ff <= topic_hi_in;
         count_ff    <= count_in;
         trunc_ff    <= trunc_in;
      end
   end

endmodule

### rtl/mqtt_publish_deframer_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   rx_byte, record_last
// rsp_      out        rsp_valid/rsp_stall   cmd_byte, byte_valid, cmd_end, cmd_length,
//                                            error_code
// csr_      in         csr_wr_en             max_command_len
//
// One request is taken per cycle while req_stall is low. A request is held in the input
// register, is parsed against the packet state and lands in the result register.
// Reset is synchronous; it clears the parse state and sets max_command_len to 1024.
// A stall on rsp_ holds the input register, and req_stall rises only while both
// registers are full.

module mqtt_publish_deframer_unit #(
   parameter int MaxLengthFieldBytes = mqttpd_pkg::DEFAULT_MAX_LENGTH_FIELD_BYTES,
   parameter int CommandCountBits    = mqttpd_pkg::DEFAULT_COMMAND_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_record_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cmd_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_cmd_end,
   output logic [15:0] rsp_cmd_length,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic [15:0]            max_len_ff;
   mqttpd_pkg::result_type out_ff, out_in;
   mqttpd_pkg::result_type core_result;
   logic                   advance;
   logic                   req_take;

   // A held request is parsed if the result register is free or drains this cycle.
   assign advance   = in_valid_ff & (~out_ff.valid | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   mqttpd_core #(
      .MaxLengthFieldBytes (MaxLengthFieldBytes),
      .CommandCountBits    (CommandCountBits)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .rx_byte         (in_byte_ff),
      .record_last     (in_last_ff),
      .max_command_len (max_len_ff),
      .result          (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         out_in = core_result;
      end else if (out_ff.valid && !rsp_stall) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
         max_len_ff   <= mqttpd_pkg::MAX_COMMAND_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_ff.valid <= out_in.valid;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_record_last;
      end
      out_ff.data       <= out_in.data;
      out_ff.byte_valid <= out_in.byte_valid;
      out_ff.cmd_end    <= out_in.cmd_end;
      out_ff.length     <= out_in.length;
      out_ff.err        <= out_in.err;
   end

   assign rsp_valid      = out_ff.valid;
   assign rsp_cmd_byte   = out_ff.data;
   assign rsp_byte_valid = out_ff.byte_valid;
   assign rsp_cmd_end    = out_ff.cmd_end;
   assign rsp_cmd_length = out_ff.length;
   assign rsp_error_code = out_ff.err;

`include "mqtt_publish_deframer_unit_assert.svh"

   // Errors are only reported on the closing result of a command.
   `MPD_ASSERT_SAME(a_err_with_end, clock, reset,
      rsp_valid && rsp_error_code != mqttpd_pkg::ERR_NONE, rsp_cmd_end)
   // A result that does not close a command always carries a payload byte.
   `MPD_ASSERT_SAME(a_mid_has_byte, clock, reset, rsp_valid && !rsp_cmd_end, rsp_byte_valid)
   // A clean end without a byte of its own is only the empty-payload marker.
   `MPD_ASSERT_SAME(a_empty_end, clock, reset,
      rsp_valid && rsp_cmd_end && !rsp_byte_valid && rsp_error_code == mqttpd_pkg::ERR_NONE,
      rsp_cmd_length == 16'd0)
   // Back-pressure reaches the request side only when both registers are occupied.
   `MPD_ASSERT_SAME(a_stall_cause, clock, reset, req_stall,
      in_valid_ff && rsp_valid && rsp_stall)

endmodule
